[hdl/gif_lzw_code_stream_encoder_core_macros.svh]
// ----------------------------------------------------------------------------
// gif lzw encoder assertion macros
// implication and next-cycle assertions, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef GIF_LZW_CODE_STREAM_ENCODER_CORE_MACROS_SVH
`define GIF_LZW_CODE_STREAM_ENCODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define GLZW_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("glzw assertion failed");
`define GLZW_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("glzw assertion failed");
`else
`define GLZW_ASSERT_IMP(label, clk, rst, ante, cons)
`define GLZW_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/glzw_pkg.sv]
// ----------------------------------------------------------------------------
// glzw_pkg
// shared constants, types and helpers of the gif lzw code stream encoder
// ----------------------------------------------------------------------------
`default_nettype none

package glzw_pkg;

  localparam int MAX_CODES    = 4096;
  localparam int SYMBOL_COUNT = 256;

  localparam int CODE_W      = $clog2(MAX_CODES);
  localparam int SYM_W       = $clog2(SYMBOL_COUNT);
  localparam int SLOT_W      = CODE_W + SYM_W;
  localparam int TABLE_DEPTH = 2 ** SLOT_W;
  localparam int NFC_W       = CODE_W + 1;
  localparam int CW_W        = 4;
  localparam int MCS_W       = 4;
  localparam int PIX_W       = 8;
  localparam int PIX_LIM_W   = PIX_W + 1;
  localparam int BYTE_W      = 8;

  localparam int MCS_MIN   = 2;
  localparam int MCS_MAX   = 8;
  localparam int MCS_RESET = 8;
  localparam int MCS_FLOOR = $clog2(SYMBOL_COUNT + 1) - 1;
  localparam int MCS_TOP   = (MCS_FLOOR < MCS_MAX) ? MCS_FLOOR : MCS_MAX;

  // packer accumulator: up to seven pending bits plus one widest code
  localparam int ACC_W  = BYTE_W - 1 + CODE_W;
  localparam int BITS_W = $clog2(ACC_W + 1);

  // code queue; an item starts only with room for its codes plus one in flight
  localparam int FIFO_DEPTH     = 16;
  localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W     = FIFO_AW + 1;
  localparam int ITEM_CODES     = 6;
  localparam int FIFO_START_MAX = FIFO_DEPTH - ITEM_CODES - 1;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CW_W-1:0]   width;
    logic              restart;
    logic              flush;
  } code_entry_t;

  function automatic logic [MCS_W-1:0] eff_mcs(input logic [MCS_W-1:0] raw);
    logic [MCS_W-1:0] m;
    m = raw;
    if (m < MCS_W'(MCS_MIN)) m = MCS_W'(MCS_MIN);
    if (m > MCS_W'(MCS_TOP)) m = MCS_W'(MCS_TOP);
    return m;
  endfunction

  function automatic logic [SYM_W-1:0] mask_sym(input logic [PIX_W-1:0] px,
                                                input logic [MCS_W-1:0] m);
    logic [PIX_LIM_W-1:0] lim;
    lim = PIX_LIM_W'(1) << m;
    return SYM_W'(px & PIX_W'(lim - PIX_LIM_W'(1)));
  endfunction

endpackage

`default_nettype wire

[hdl/glzw_ifs.sv]
// ----------------------------------------------------------------------------
// glzw channel interfaces
// pixel input channel and code stream byte output channel, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface glzw_pixel_if;
  import glzw_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_index;
  logic             frame_first;
  logic             frame_last;

  modport source (output valid, pixel_index, frame_first, frame_last, input ready);
  modport sink (input valid, pixel_index, frame_first, frame_last, output ready);
endinterface

interface glzw_byte_if;
  import glzw_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              stream_end;

  modport source (output valid, out_byte, stream_end, input ready);
  modport sink (input valid, out_byte, stream_end, output ready);
endinterface

`default_nettype wire

[hdl/gif_lzw_code_stream_encoder_core.sv]
// ----------------------------------------------------------------------------
// gif_lzw_code_stream_encoder_core
// pacing: a pixel inside a frame is set by the input buffer and the child then
//   back-pointer memory reads (S_READ, then S_CHECK); a full dictionary adds
//   S_FULL, a frame's last pixel S_LAST1 to S_LAST3
// output: bytes leave at up to one per cycle while byte_out is ready
// reset: synchronous, min_code_size back to 8; no memory clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

`include "gif_lzw_code_stream_encoder_core_macros.svh"

module gif_lzw_code_stream_encoder_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [glzw_pkg::MCS_W-1:0] cfg_wr_data,
  glzw_pixel_if.sink                pixel_in,
  glzw_byte_if.source               byte_out
);
  import glzw_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_FULL  = 7'b0001000,
    S_LAST1 = 7'b0010000,
    S_LAST2 = 7'b0100000,
    S_LAST3 = 7'b1000000
  } state_t;

  state_t             state;
  logic [MCS_W-1:0]   min_code_size;
  logic [MCS_W-1:0]   frame_mcs;
  logic [CODE_W-1:0]  prefix;
  logic [NFC_W-1:0]   nfc;
  logic [CW_W-1:0]    cw;
  logic               active;

  logic               ibuf_valid;
  logic [PIX_W-1:0]   ibuf_pixel;
  logic               ibuf_first;
  logic               ibuf_last;

  logic [SYM_W-1:0]   sym_q;
  logic               last_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [CODE_W-1:0]  c_q;

  // dictionary: child code per (prefix, symbol), and slot per allocated code
  logic [CODE_W-1:0]  child_mem [TABLE_DEPTH];
  logic [SLOT_W-1:0]  back_mem [MAX_CODES];
  logic [CODE_W-1:0]  child_q;
  logic [SLOT_W-1:0]  back_q;
  logic               fwd_hit;
  logic [CODE_W-1:0]  fwd_data;

  logic [CODE_W-1:0]  child_data;
  logic               child_rd_en;
  logic [SLOT_W-1:0]  child_rd_addr;
  logic               child_we;

  logic [MCS_W-1:0]   start_mcs;
  logic [CODE_W-1:0]  start_clear;
  logic [SYM_W-1:0]   start_sym;
  logic [SYM_W-1:0]   ibuf_sym;
  logic [CODE_W-1:0]  clr_code;
  logic [NFC_W-1:0]   dict_nfc;
  logic [NFC_W-1:0]   nfc_inc;
  logic               full;
  logic               cw_grow;
  logic [CW_W-1:0]    cw_next;
  logic               hit_raw;
  logic               hit;
  logic [CODE_W-1:0]  next_prefix;
  logic               start;
  logic               take_idle;
  logic               chain;
  logic               fifo_room;
  logic               push;
  code_entry_t        push_entry;

  assign pixel_in.ready = !ibuf_valid;

  assign start_mcs   = eff_mcs(min_code_size);
  assign start_clear = CODE_W'(1) << start_mcs;
  assign start_sym   = mask_sym(ibuf_pixel, start_mcs);
  assign ibuf_sym    = mask_sym(ibuf_pixel, frame_mcs);
  assign clr_code    = CODE_W'(1) << frame_mcs;
  assign dict_nfc    = NFC_W'(clr_code) + NFC_W'(2);
  assign nfc_inc     = nfc + NFC_W'(1);
  assign full        = (nfc_inc >= NFC_W'(MAX_CODES));
  assign cw_grow     = (cw < CW_W'(CODE_W)) && (nfc == (NFC_W'(1) << cw));
  assign cw_next     = cw_grow ? cw + CW_W'(1) : cw;
  assign child_data  = fwd_hit ? fwd_data : child_q;

  assign hit_raw = (NFC_W'(c_q) >= dict_nfc) && (NFC_W'(c_q) < nfc) && (back_q == slot_q);

  // an entry never written reads as a miss
  always_comb begin
    hit = 1'b0;
    if (hit_raw) hit = 1'b1;
  end

  always_comb begin
    next_prefix = CODE_W'(sym_q);
    if (hit) next_prefix = c_q;
  end

  assign start     = ibuf_first || !active;
  assign take_idle = (state == S_IDLE) && ibuf_valid && fifo_room;
  assign chain     = (state == S_CHECK) && !(!hit && full) && !last_q && ibuf_valid
                     && !ibuf_first && fifo_room;
  assign child_we  = (state == S_CHECK) && !hit;

  always_comb begin
    child_rd_en   = 1'b0;
    child_rd_addr = {prefix, ibuf_sym};
    if (take_idle && !start) begin
      child_rd_en = 1'b1;
    end
    if (chain) begin
      child_rd_en   = 1'b1;
      child_rd_addr = {next_prefix, ibuf_sym};
    end
  end

  always_comb begin
    push       = 1'b0;
    push_entry = '{code: prefix, width: cw, restart: 1'b0, flush: 1'b0};
    unique case (state)
      S_IDLE: begin
        if (take_idle && start) begin
          push       = 1'b1;
          push_entry = '{code: start_clear, width: start_mcs + CW_W'(1),
                         restart: 1'b1, flush: 1'b0};
        end
      end
      S_CHECK: push = !hit;
      S_FULL: begin
        push            = 1'b1;
        push_entry.code = clr_code;
      end
      S_LAST1: push = 1'b1;
      S_LAST2: begin
        push            = 1'b1;
        push_entry.code = clr_code;
      end
      S_LAST3: begin
        push             = 1'b1;
        push_entry.code  = clr_code + CODE_W'(1);
        push_entry.flush = 1'b1;
      end
      S_READ: push = 1'b0;
      default: push = 1'b0;
    endcase
  end

  // child memory, with forwarding when a read meets the write to its entry
  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[slot_q] <= nfc[CODE_W-1:0];
    end
    if (child_rd_en) begin
      child_q <= child_mem[child_rd_addr];
    end
    fwd_data <= nfc[CODE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (child_we) begin
      back_mem[nfc[CODE_W-1:0]] <= slot_q;
    end
    if (state == S_READ) begin
      back_q <= back_mem[child_data];
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_in.valid && pixel_in.ready) begin
      ibuf_pixel <= pixel_in.pixel_index;
      ibuf_first <= pixel_in.frame_first;
      ibuf_last  <= pixel_in.frame_last;
    end
    if (take_idle || chain) begin
      sym_q  <= ibuf_sym;
      last_q <= ibuf_last;
      slot_q <= child_rd_addr;
    end
    if (state == S_READ) begin
      c_q <= child_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      min_code_size <= MCS_W'(MCS_RESET);
      frame_mcs     <= eff_mcs(MCS_W'(MCS_RESET));
      cw            <= eff_mcs(MCS_W'(MCS_RESET)) + CW_W'(1);
      nfc           <= (NFC_W'(1) << eff_mcs(MCS_W'(MCS_RESET))) + NFC_W'(2);
      prefix        <= '0;
      active        <= 1'b0;
      ibuf_valid    <= 1'b0;
      fwd_hit       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        min_code_size <= cfg_wr_data;
      end
      if (pixel_in.valid && pixel_in.ready) begin
        ibuf_valid <= 1'b1;
      end else if (take_idle || chain) begin
        ibuf_valid <= 1'b0;
      end
      fwd_hit <= child_rd_en && child_we && (child_rd_addr == slot_q);

      unique case (state)
        S_IDLE: begin
          if (take_idle) begin
            if (start) begin
              frame_mcs <= start_mcs;
              cw        <= start_mcs + CW_W'(1);
              nfc       <= NFC_W'(start_clear) + NFC_W'(2);
              prefix    <= CODE_W'(start_sym);
              active    <= 1'b1;
              state     <= ibuf_last ? S_LAST1 : S_IDLE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          prefix <= next_prefix;
          if (!hit) begin
            cw  <= cw_next;
            nfc <= nfc_inc;
          end
          if (!hit && full) begin
            state <= S_FULL;
          end else if (last_q) begin
            state <= S_LAST1;
          end else if (chain) begin
            state <= S_READ;
          end else begin
            state <= S_IDLE;
          end
        end
        S_FULL: begin
          cw    <= frame_mcs + CW_W'(1);
          nfc   <= dict_nfc;
          state <= last_q ? S_LAST1 : S_IDLE;
        end
        S_LAST1: state <= S_LAST2;
        S_LAST2: state <= S_LAST3;
        S_LAST3: begin
          cw     <= frame_mcs + CW_W'(1);
          nfc    <= dict_nfc;
          prefix <= '0;
          active <= 1'b0;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  glzw_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .room       (fifo_room),
    .byte_out   (byte_out)
  );

  `GLZW_ASSERT_IMP(a_nfc_range, clk, rst, state != S_FULL, nfc < NFC_W'(MAX_CODES))
  `GLZW_ASSERT_IMP(a_prefix_known, clk, rst, active && state == S_IDLE, NFC_W'(prefix) < nfc)
  `GLZW_ASSERT_IMP(a_width_range, clk, rst, 1'b1, cw > frame_mcs && cw <= CW_W'(CODE_W))
  `GLZW_ASSERT_NXT(a_miss_allocates, clk, rst, state == S_CHECK && !hit && !full, nfc == $past(nfc) + NFC_W'(1))

endmodule

`default_nettype wire

[hdl/glzw_packer.sv]
// ----------------------------------------------------------------------------
// glzw_packer
// code queue and lsb-first bit packer, up to one byte transaction per cycle while the sink is ready
// ----------------------------------------------------------------------------
`default_nettype none

module glzw_packer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  glzw_pkg::code_entry_t push_entry,
  output logic                  room,
  glzw_byte_if.source           byte_out
);
  import glzw_pkg::*;

  code_entry_t            fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr;
  logic [FIFO_AW-1:0]     rd_ptr;
  logic [FIFO_CNT_W-1:0]  count;

  logic [ACC_W-1:0]       acc;
  logic [BITS_W-1:0]      bits;
  logic                   flushing;

  logic                   out_valid;
  logic [BYTE_W-1:0]      out_data;
  logic                   out_end;

  code_entry_t            head;
  logic                   out_free;
  logic                   can_emit;
  logic                   emit;
  logic                   pop;
  logic [ACC_W-1:0]       acc_e;
  logic [BITS_W-1:0]      bits_e;
  logic [BYTE_W-1:0]      base_acc;
  logic [BITS_W-1:0]      base_bits;
  logic [ACC_W-1:0]       acc_n;
  logic [BITS_W-1:0]      bits_n;

  assign head     = fifo[rd_ptr];
  assign room     = (count <= FIFO_CNT_W'(FIFO_START_MAX));
  assign out_free = !out_valid || byte_out.ready;

  always_comb begin
    if (flushing) begin
      can_emit = (bits != '0);
    end else begin
      can_emit = (bits >= BITS_W'(BYTE_W));
    end
    emit = can_emit && out_free;
    if (emit) begin
      acc_e = acc >> BYTE_W;
      if (bits > BITS_W'(BYTE_W)) begin
        bits_e = bits - BITS_W'(BYTE_W);
      end else begin
        bits_e = '0;
      end
    end else begin
      acc_e  = acc;
      bits_e = bits;
    end
    pop = !flushing && !(can_emit && !out_free) && (count != '0)
          && (bits_e < BITS_W'(BYTE_W));
    // frame start drops any partial byte
    if (head.restart) begin
      base_acc  = '0;
      base_bits = '0;
    end else begin
      base_acc  = acc_e[BYTE_W-1:0];
      base_bits = bits_e;
    end
    acc_n  = ACC_W'(base_acc) | (ACC_W'(head.code) << base_bits);
    bits_n = base_bits + BITS_W'(head.width);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      acc       <= '0;
      bits      <= '0;
      flushing  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);

      if (pop) begin
        acc      <= acc_n;
        bits     <= bits_n;
        flushing <= head.flush;
      end else if (emit) begin
        acc  <= acc_e;
        bits <= bits_e;
        if (flushing && bits_e == '0) begin
          flushing <= 1'b0;
        end
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (byte_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= acc[BYTE_W-1:0];
      out_end  <= flushing && (bits <= BITS_W'(BYTE_W));
    end
  end

  assign byte_out.valid      = out_valid;
  assign byte_out.out_byte   = out_data;
  assign byte_out.stream_end = out_end;

endmodule

`default_nettype wire
